>>> rtl/wsd_pkg.sv
// Shared types, command and register codes, and the two regulation tables
// for the wheel steering drive decoder. No dependencies.

package wsd_pkg;

  localparam int unsigned DutyW   = 16;
  localparam int unsigned ClawW   = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CmdW    = 4;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CmdW-1:0] {
    CmdStop       = 4'd0,
    CmdForward    = 4'd1,
    CmdBackward   = 4'd2,
    CmdRotRight   = 4'd3,
    CmdRotLeft    = 4'd4,
    CmdTurnRight  = 4'd5,
    CmdTurnLeft   = 4'd6,
    CmdTightRight = 4'd7,
    CmdTightLeft  = 4'd8,
    CmdClawOpen   = 4'd9,
    CmdClawClose  = 4'd10,
    CmdRegForward = 4'd11,
    CmdRegBack    = 4'd12
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBaseSpeed   = 3'd0,
    CfgFastSpeed   = 3'd1,
    CfgSlowSpeed   = 3'd2,
    CfgNormalSpeed = 3'd3,
    CfgClawOpen    = 3'd4,
    CfgClawClosed  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [DutyW-1:0] neutral_speed;
    logic [DutyW-1:0] fast_speed;
    logic [DutyW-1:0] slow_speed;
    logic [DutyW-1:0] normal_speed;
    logic [ClawW-1:0] claw_open_duty;
    logic [ClawW-1:0] claw_closed_duty;
  } cfg_t;

  typedef struct packed {
    logic [DutyW-1:0] right;
    logic [DutyW-1:0] left;
  } bin_t;

  localparam logic [DutyW-1:0] BaseSpeedRst   = 16'd30000;
  localparam logic [DutyW-1:0] FastSpeedRst   = 16'd45000;
  localparam logic [DutyW-1:0] SlowSpeedRst   = 16'd15000;
  localparam logic [DutyW-1:0] NormalSpeedRst = 16'd30000;
  localparam logic [ClawW-1:0] ClawOpenRst    = 8'd25;
  localparam logic [ClawW-1:0] ClawClosedRst  = 8'd20;

  // Heading angle: first bin whose lower bound the angle reaches.
  function automatic bin_t angle_bin(input logic [ByteW-1:0] v);
    bin_t b;
    priority if (v >= 8'd116) b = '{16'd20435, 16'd39565};
    else if (v >= 8'd111)     b = '{16'd22066, 16'd37934};
    else if (v >= 8'd108)     b = '{16'd24076, 16'd35924};
    else if (v >= 8'd105)     b = '{16'd26063, 16'd33937};
    else if (v >= 8'd102)     b = '{16'd28035, 16'd31965};
    else if (v >= 8'd99)      b = '{16'd30000, 16'd30000};
    else if (v >= 8'd96)      b = '{16'd31965, 16'd28035};
    else if (v >= 8'd93)      b = '{16'd33937, 16'd26063};
    else if (v >= 8'd90)      b = '{16'd35924, 16'd24076};
    else if (v >= 8'd85)      b = '{16'd37934, 16'd22066};
    else                      b = '{16'd39565, 16'd20435};
    return b;
  endfunction

  // Lane offset: same search; two entries near the low end break the mirror
  // symmetry.
  function automatic bin_t offset_bin(input logic [ByteW-1:0] v);
    bin_t b;
    priority if (v >= 8'd142) b = '{16'd23400, 16'd36600};
    else if (v >= 8'd132)     b = '{16'd25560, 16'd34440};
    else if (v >= 8'd123)     b = '{16'd26700, 16'd33300};
    else if (v >= 8'd115)     b = '{16'd27720, 16'd32280};
    else if (v >= 8'd108)     b = '{16'd28740, 16'd31260};
    else if (v >= 8'd102)     b = '{16'd29520, 16'd30480};
    else if (v >= 8'd99)      b = '{16'd30000, 16'd30000};
    else if (v >= 8'd93)      b = '{16'd30480, 16'd29520};
    else if (v >= 8'd86)      b = '{16'd31260, 16'd28740};
    else if (v >= 8'd78)      b = '{16'd32280, 16'd27720};
    else if (v >= 8'd69)      b = '{16'd33330, 16'd26700};
    else if (v >= 8'd59)      b = '{16'd34440, 16'd25560};
    else                      b = '{16'd36600, 16'd22400};
    return b;
  endfunction

endpackage

>>> rtl/wsd_cfg_regs.sv
// Configuration register file: speeds and claw duties.
// Depends on wsd_pkg.

module wsd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wsd_pkg::DutyW-1:0]    cfg_data_i,
  output wsd_pkg::cfg_t                cfg_o
);
  import wsd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      // indexes past the list are dropped
      unique case (cfg_idx_e'(cfg_index_i))
        CfgBaseSpeed:   cfg_d.neutral_speed    = cfg_data_i;
        CfgFastSpeed:   cfg_d.fast_speed       = cfg_data_i;
        CfgSlowSpeed:   cfg_d.slow_speed       = cfg_data_i;
        CfgNormalSpeed: cfg_d.normal_speed     = cfg_data_i;
        CfgClawOpen:    cfg_d.claw_open_duty   = cfg_data_i[ClawW-1:0];
        CfgClawClosed:  cfg_d.claw_closed_duty = cfg_data_i[ClawW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{BaseSpeedRst, FastSpeedRst, SlowSpeedRst, NormalSpeedRst,
                 ClawOpenRst, ClawClosedRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/wsd_regulate.sv
// Regulated drive: angle and offset table lookups, per-side sum minus base.
// Depends on wsd_pkg.

module wsd_regulate (
  input  logic [wsd_pkg::ByteW-1:0] steer_angle_i,
  input  logic [wsd_pkg::ByteW-1:0] lane_offset_i,
  input  logic [wsd_pkg::DutyW-1:0] neutral_speed_i,
  output logic [wsd_pkg::DutyW-1:0] right_duty_o,
  output logic [wsd_pkg::DutyW-1:0] left_duty_o
);
  import wsd_pkg::*;

  bin_t a_bin, o_bin;

  assign a_bin = angle_bin(steer_angle_i);
  assign o_bin = offset_bin(lane_offset_i);

  // wraps mod 2^16, no saturation
  assign right_duty_o = DutyW'(a_bin.right + o_bin.right - neutral_speed_i);
  assign left_duty_o  = DutyW'(a_bin.left + o_bin.left - neutral_speed_i);

endmodule

>>> rtl/wheel_steering_drive_decoder.sv
// Top level of the wheel steering drive decoder: input register, command
// decode and the state/result register. Depends on wsd_pkg, wsd_cfg_regs
// and wsd_regulate.
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   cmd_i, steer_angle_i, lane_offset_i
//   out      out_valid_o / out_ready_i right/left_forward_o, right/left_duty_o,
//                                      claw_duty_o
//   cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One command per cycle sustained while the output is not stalled; each command
// passes through the input register, then the result register.
// The result register is also the drive state, so each command sees the
// state left by the one before it.
// Reset: directions forward, wheel duties 0, claw open, registers at defaults.
// A stalled output holds the input register; cfg_ready_o is always high.

module wheel_steering_drive_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wsd_pkg::CmdW-1:0]     cmd_i,
  input  logic [wsd_pkg::ByteW-1:0]    steer_angle_i,
  input  logic [wsd_pkg::ByteW-1:0]    lane_offset_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         right_forward_o,
  output logic                         left_forward_o,
  output logic [wsd_pkg::DutyW-1:0]    right_duty_o,
  output logic [wsd_pkg::DutyW-1:0]    left_duty_o,
  output logic [wsd_pkg::ClawW-1:0]    claw_duty_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wsd_pkg::DutyW-1:0]    cfg_data_i
);
  import wsd_pkg::*;

  cfg_t cfg;

  logic             in_vld_q;
  logic [CmdW-1:0]  cmd_q;
  logic [ByteW-1:0] angle_q, offset_q;

  logic             out_vld_q;
  logic             rdir_q, rdir_d, ldir_q, ldir_d;
  logic [DutyW-1:0] rduty_q, rduty_d, lduty_q, lduty_d;
  logic [ClawW-1:0] claw_q, claw_d;

  logic [DutyW-1:0] reg_right, reg_left;
  logic             out_free, advance, in_take;

  wsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wsd_regulate u_reg (
    .steer_angle_i   (angle_q),
    .lane_offset_i   (offset_q),
    .neutral_speed_i (cfg.neutral_speed),
    .right_duty_o    (reg_right),
    .left_duty_o     (reg_left)
  );

  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    rdir_d  = rdir_q;
    ldir_d  = ldir_q;
    rduty_d = rduty_q;
    lduty_d = lduty_q;
    claw_d  = claw_q;
    unique case (cmd_e'(cmd_q))
      CmdStop: begin
        rduty_d = '0;
        lduty_d = '0;
      end
      CmdForward: begin
        {rdir_d, ldir_d}   = 2'b11;
        {rduty_d, lduty_d} = {cfg.fast_speed, cfg.fast_speed};
      end
      CmdBackward: begin
        {rdir_d, ldir_d}   = 2'b00;
        {rduty_d, lduty_d} = {cfg.fast_speed, cfg.fast_speed};
      end
      CmdRotRight: begin
        {rdir_d, ldir_d}   = 2'b01;
        {rduty_d, lduty_d} = {cfg.fast_speed, cfg.fast_speed};
      end
      CmdRotLeft: begin
        {rdir_d, ldir_d}   = 2'b10;
        {rduty_d, lduty_d} = {cfg.fast_speed, cfg.fast_speed};
      end
      CmdTurnRight: begin
        {rdir_d, ldir_d}   = 2'b11;
        {rduty_d, lduty_d} = {cfg.slow_speed, cfg.fast_speed};
      end
      CmdTurnLeft: begin
        {rdir_d, ldir_d}   = 2'b11;
        {rduty_d, lduty_d} = {cfg.fast_speed, cfg.slow_speed};
      end
      CmdTightRight: begin
        {rdir_d, ldir_d}   = 2'b01;
        {rduty_d, lduty_d} = {cfg.slow_speed, cfg.fast_speed};
      end
      CmdTightLeft: begin
        {rdir_d, ldir_d}   = 2'b10;
        {rduty_d, lduty_d} = {cfg.fast_speed, cfg.normal_speed};
      end
      CmdClawOpen:  claw_d = cfg.claw_open_duty;
      CmdClawClose: claw_d = cfg.claw_closed_duty;
      CmdRegForward: begin
        {rdir_d, ldir_d}   = 2'b11;
        {rduty_d, lduty_d} = {reg_right, reg_left};
      end
      CmdRegBack: begin
        {rdir_d, ldir_d}   = 2'b00;
        {rduty_d, lduty_d} = {reg_right, reg_left};
      end
      default: ; // unused codes keep the state
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q    <= cmd_i;
      angle_q  <= steer_angle_i;
      offset_q <= lane_offset_i;
    end
  end

  // result register doubles as the drive state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      rdir_q    <= 1'b1;
      ldir_q    <= 1'b1;
      rduty_q   <= '0;
      lduty_q   <= '0;
      claw_q    <= ClawOpenRst;
    end else begin
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (advance) begin
        rdir_q  <= rdir_d;
        ldir_q  <= ldir_d;
        rduty_q <= rduty_d;
        lduty_q <= lduty_d;
        claw_q  <= claw_d;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign right_forward_o = rdir_q;
  assign left_forward_o  = ldir_q;
  assign right_duty_o    = rduty_q;
  assign left_duty_o     = lduty_q;
  assign claw_duty_o     = claw_q;

endmodule

>>> tb/wheel_steering_drive_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for wheel_steering_drive_decoder: directed and random
// drive commands under several register settings and idle patterns, checked
// against a scoreboard that tracks the drive state. Depends on wsd_pkg and wheel_steering_drive_decoder.

module wheel_steering_drive_decoder_tb;
  import wsd_pkg::*;

  localparam int          Phases        = 8;
  localparam int          ItemsPerPhase = 250;
  localparam int          StallLimit    = 1000;
  localparam int          MaxPrinted    = 40;
  localparam int          AngleBins     = 11;
  localparam int          OffsetBins    = 13;

  // Command and register codes the block must ignore.
  localparam logic [CmdW-1:0]    CmdSpareLo  = 4'd13;
  localparam logic [CmdW-1:0]    CmdSpareMid = 4'd14;
  localparam logic [CmdW-1:0]    CmdSpareHi  = 4'd15;
  localparam logic [CfgIdxW-1:0] CfgSpareLo  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi  = 3'd7;

  localparam logic [ByteW-1:0] AngleLow [AngleBins] = '{
    8'd116, 8'd111, 8'd108, 8'd105, 8'd102, 8'd99, 8'd96, 8'd93, 8'd90, 8'd85, 8'd0};
  localparam logic [DutyW-1:0] AngleRight [AngleBins] = '{
    16'd20435, 16'd22066, 16'd24076, 16'd26063, 16'd28035, 16'd30000,
    16'd31965, 16'd33937, 16'd35924, 16'd37934, 16'd39565};
  localparam logic [DutyW-1:0] AngleLeft [AngleBins] = '{
    16'd39565, 16'd37934, 16'd35924, 16'd33937, 16'd31965, 16'd30000,
    16'd28035, 16'd26063, 16'd24076, 16'd22066, 16'd20435};

  localparam logic [ByteW-1:0] OffsetLow [OffsetBins] = '{
    8'd142, 8'd132, 8'd123, 8'd115, 8'd108, 8'd102, 8'd99,
    8'd93, 8'd86, 8'd78, 8'd69, 8'd59, 8'd0};
  // Lower end is not symmetric: 33330 and 22400 on purpose.
  localparam logic [DutyW-1:0] OffsetRight [OffsetBins] = '{
    16'd23400, 16'd25560, 16'd26700, 16'd27720, 16'd28740, 16'd29520, 16'd30000,
    16'd30480, 16'd31260, 16'd32280, 16'd33330, 16'd34440, 16'd36600};
  localparam logic [DutyW-1:0] OffsetLeft [OffsetBins] = '{
    16'd36600, 16'd34440, 16'd33300, 16'd32280, 16'd31260, 16'd30480, 16'd30000,
    16'd29520, 16'd28740, 16'd27720, 16'd26700, 16'd25560, 16'd22400};

  typedef struct packed {
    logic             right_fwd;
    logic             left_fwd;
    logic [DutyW-1:0] right_duty;
    logic [DutyW-1:0] left_duty;
    logic [ClawW-1:0] claw_duty;
  } drive_state_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [CmdW-1:0]     cmd_i         = '0;
  logic [ByteW-1:0]    steer_angle_i = '0;
  logic [ByteW-1:0]    lane_offset_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic                right_forward_o;
  logic                left_forward_o;
  logic [DutyW-1:0]    right_duty_o;
  logic [DutyW-1:0]    left_duty_o;
  logic [ClawW-1:0]    claw_duty_o;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [DutyW-1:0]    cfg_data_i    = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_cycles   = 0;
  int unsigned cfg_writes     = 0;

  function automatic int angle_slot(input logic [ByteW-1:0] v);
    for (int i = 0; i < AngleBins - 1; i++) begin
      if (v >= AngleLow[i]) return i;
    end
    return AngleBins - 1;
  endfunction

  function automatic int offset_slot(input logic [ByteW-1:0] v);
    for (int i = 0; i < OffsetBins - 1; i++) begin
      if (v >= OffsetLow[i]) return i;
    end
    return OffsetBins - 1;
  endfunction

  class drive_scoreboard;
    cfg_t         settings;
    drive_state_t held;
    drive_state_t expected_states[$];
    int unsigned  errors;
    int unsigned  compared;
    int unsigned  commands;
    int unsigned  regulated;

    function new();
      settings = '{BaseSpeedRst, FastSpeedRst, SlowSpeedRst, NormalSpeedRst,
                   ClawOpenRst, ClawClosedRst};
      held     = '{1'b1, 1'b1, '0, '0, ClawOpenRst};
      errors    = 0;
      compared  = 0;
      commands  = 0;
      regulated = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MaxPrinted) $display("%0t MISMATCH: %s", $realtime, msg);
    endtask

    function int unsigned pending();
      return expected_states.size();
    endfunction

    function void set_register(input logic [CfgIdxW-1:0] idx,
                               input logic [DutyW-1:0] data);
      case (idx)
        CfgBaseSpeed:   settings.neutral_speed    = data;
        CfgFastSpeed:   settings.fast_speed       = data;
        CfgSlowSpeed:   settings.slow_speed       = data;
        CfgNormalSpeed: settings.normal_speed     = data;
        CfgClawOpen:    settings.claw_open_duty   = data[ClawW-1:0];
        CfgClawClosed:  settings.claw_closed_duty = data[ClawW-1:0];
        default: ;
      endcase
    endfunction

    function void set_wheels(input logic rfwd, input logic lfwd,
                             input logic [DutyW-1:0] rduty, input logic [DutyW-1:0] lduty);
      held.right_fwd  = rfwd;
      held.left_fwd   = lfwd;
      held.right_duty = rduty;
      held.left_duty  = lduty;
    endfunction

    // Sum of both table entries minus base speed, wrapping at 16 bits.
    function void regulate(input logic fwd, input logic [ByteW-1:0] angle,
                           input logic [ByteW-1:0] offset);
      int               a;
      int               o;
      logic [DutyW-1:0] rduty;
      logic [DutyW-1:0] lduty;
      a = angle_slot(angle);
      o = offset_slot(offset);
      rduty = AngleRight[a] + OffsetRight[o] - settings.neutral_speed;
      lduty = AngleLeft[a] + OffsetLeft[o] - settings.neutral_speed;
      set_wheels(fwd, fwd, rduty, lduty);
      regulated++;
    endfunction

    function void note_command(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] angle,
                               input logic [ByteW-1:0] offset);
      logic [DutyW-1:0] fast;
      logic [DutyW-1:0] slow;
      fast = settings.fast_speed;
      slow = settings.slow_speed;
      case (cmd)
        CmdStop: begin
          held.right_duty = '0;
          held.left_duty  = '0;
        end
        CmdForward:    set_wheels(1'b1, 1'b1, fast, fast);
        CmdBackward:   set_wheels(1'b0, 1'b0, fast, fast);
        CmdRotRight:   set_wheels(1'b0, 1'b1, fast, fast);
        CmdRotLeft:    set_wheels(1'b1, 1'b0, fast, fast);
        CmdTurnRight:  set_wheels(1'b1, 1'b1, slow, fast);
        CmdTurnLeft:   set_wheels(1'b1, 1'b1, fast, slow);
        CmdTightRight: set_wheels(1'b0, 1'b1, slow, fast);
        CmdTightLeft:  set_wheels(1'b1, 1'b0, fast, settings.normal_speed);
        CmdClawOpen:   held.claw_duty = settings.claw_open_duty;
        CmdClawClose:  held.claw_duty = settings.claw_closed_duty;
        CmdRegForward: regulate(1'b1, angle, offset);
        CmdRegBack:    regulate(1'b0, angle, offset);
        default: ;  // unused codes leave the state alone
      endcase
      expected_states.push_back(held);
      commands++;
    endfunction

    task check_field(input string name, input int unsigned got, input int unsigned exp);
      if (got != exp)
        report($sformatf("result %0d %s got %0d expected %0d", compared, name, got, exp));
    endtask

    task check_state(input drive_state_t got);
      drive_state_t exp;
      if (expected_states.size() == 0) begin
        report($sformatf("result with no command outstanding: %p", got));
      end else begin
        exp = expected_states.pop_front();
        check_field("right_forward", got.right_fwd, exp.right_fwd);
        check_field("left_forward", got.left_fwd, exp.left_fwd);
        check_field("right_duty", got.right_duty, exp.right_duty);
        check_field("left_duty", got.left_duty, exp.left_duty);
        check_field("claw_duty", got.claw_duty, exp.claw_duty);
      end
      compared++;
    endtask
  endclass

  drive_scoreboard drive_sb = new();

  wheel_steering_drive_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .steer_angle_i  (steer_angle_i),
    .lane_offset_i  (lane_offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .right_forward_o(right_forward_o),
    .left_forward_o (left_forward_o),
    .right_duty_o   (right_duty_o),
    .left_duty_o    (left_duty_o),
    .claw_duty_o    (claw_duty_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Transaction monitor: feeds the scoreboard and tracks idle cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        drive_sb.note_command(cmd_i, steer_angle_i, lane_offset_i);
      if (out_valid_o && out_ready_i)
        drive_sb.check_state('{right_forward_o, left_forward_o, right_duty_o,
                               left_duty_o, claw_duty_o});
      if (cfg_valid_i && cfg_ready_o) begin
        drive_sb.set_register(cfg_index_i, cfg_data_i);
        cfg_writes <= cfg_writes + 1;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $realtime, StallLimit);
    $display("wheel_steering_drive_decoder_tb failed");
    $finish;
  end

  task automatic send_cmd(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] angle,
                          input logic [ByteW-1:0] offset);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    steer_angle_i <= angle;
    lane_offset_i <= offset;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    if ($urandom_range(99) < 70) return ByteW'($urandom_range(50, 160));
    return ByteW'($urandom_range(255));
  endfunction

  task automatic send_random();
    int unsigned     pick;
    logic [CmdW-1:0] cmd;
    pick = $urandom_range(99);
    if (pick < 40)
      cmd = ($urandom_range(1) != 0) ? CmdRegForward : CmdRegBack;
    else if (pick < 90)
      cmd = CmdW'($urandom_range(CmdStop, CmdClawClose));
    else
      cmd = CmdW'($urandom_range(CmdSpareLo, CmdSpareHi));
    send_cmd(cmd, pick_byte(), pick_byte());
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (drive_sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DutyW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // mode 1: all ones, mode 2: all zeros, otherwise random; in modes 1 and 2 a
  // spare index gets junk that must not land anywhere.
  task automatic load_settings(input int mode);
    logic [DutyW-1:0] vals[6];
    for (int i = 0; i < 6; i++) begin
      case (mode)
        1:       vals[i] = '1;
        2:       vals[i] = '0;
        default: vals[i] = DutyW'($urandom_range(16'hFFFF));
      endcase
    end
    write_reg(CfgBaseSpeed, vals[0]);
    write_reg(CfgFastSpeed, vals[1]);
    write_reg(CfgSlowSpeed, vals[2]);
    write_reg(CfgNormalSpeed, vals[3]);
    write_reg(CfgClawOpen, vals[4]);
    write_reg(CfgClawClosed, vals[5]);
    if (mode == 1) write_reg(CfgSpareLo, DutyW'($urandom_range(16'hFFFF)));
    if (mode == 2) write_reg(CfgSpareHi, DutyW'($urandom_range(16'hFFFF)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    send_cmd(CmdForward, pick_byte(), pick_byte());
    send_cmd(CmdStop, pick_byte(), pick_byte());
    send_cmd(CmdBackward, pick_byte(), pick_byte());
    send_cmd(CmdStop, pick_byte(), pick_byte());      // directions stay backward
    send_cmd(CmdRotRight, pick_byte(), pick_byte());
    send_cmd(CmdRotLeft, pick_byte(), pick_byte());
    send_cmd(CmdTurnRight, pick_byte(), pick_byte());
    send_cmd(CmdTurnLeft, pick_byte(), pick_byte());
    send_cmd(CmdTightRight, pick_byte(), pick_byte());
    send_cmd(CmdTightLeft, pick_byte(), pick_byte());
    send_cmd(CmdClawClose, pick_byte(), pick_byte());
    send_cmd(CmdClawOpen, pick_byte(), pick_byte());
    send_cmd(CmdRegForward, 8'd0, 8'd0);
    send_cmd(CmdRegForward, 8'd255, 8'd255);
    send_cmd(CmdRegBack, 8'd116, 8'd142);
    send_cmd(CmdRegBack, 8'd115, 8'd141);
    send_cmd(CmdRegForward, 8'd85, 8'd59);
    send_cmd(CmdRegForward, 8'd84, 8'd58);
    send_cmd(CmdRegBack, 8'd99, 8'd99);
    send_cmd(CmdSpareLo, 8'd0, 8'd255);
    send_cmd(CmdSpareMid, 8'd255, 8'd0);
    send_cmd(CmdSpareHi, pick_byte(), pick_byte());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int phase = 0; phase < Phases; phase++) begin
      if (phase > 0) begin
        wait_for_results();
        repeat (4) @(posedge clk_i);
        load_settings(phase);
      end
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (phase == 0) run_directed();
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n == ItemsPerPhase / 2) wait_for_results();
        send_random();
      end
    end
    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d commands (%0d regulated) and %0d register writes over %0d phases;",
             drive_sb.commands, drive_sb.regulated, cfg_writes, Phases);
    $display("%0d results compared, %0d mismatches.", drive_sb.compared, drive_sb.errors);
    if (drive_sb.errors == 0)
      $display("wheel_steering_drive_decoder_tb passed");
    else
      $display("wheel_steering_drive_decoder_tb failed");
    $finish;
  end

endmodule
